@@ rtl/dwvp_pkg.sv @@
// Shared types and constants for the dual-wheel velocity PID unit.
// No dependencies; imported by every other file in rtl/.
`default_nettype none

package dwvp_pkg;

    localparam int GAIN_W    = 24;
    localparam int TRACK_W   = 10;
    localparam int SCALE_W   = 16;
    localparam int LIN_W     = 13;
    localparam int TURN_W    = 16;
    localparam int PWM_W     = 8;
    localparam int ERR_W     = 32;
    localparam int VEL_W     = 28;   // twice the wheel speed, Q.12
    localparam int BASE_SH   = 13;   // lin * 2 * 4096
    localparam int SETP_W    = 43;   // |2v| (27 bits) * ticks_scale (16 bits)
    localparam int SET_SH_BASE = 29; // set shift is this minus FRAC_BITS

    localparam int MUL_A_W   = 34;   // signed multiplicand
    localparam int MUL_B_W   = 24;   // unsigned multiplier, one bit per cycle
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = PROD_W + 2;

    localparam int DRV_MAX_INT = 255;

    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int OUT_W     = 24;

    localparam logic [ERR_W-1:0] ERR_MAX = 32'h7FFF_FFFF;
    localparam logic [ERR_W-1:0] ERR_MIN = 32'h8000_0000;

    localparam logic [GAIN_W-1:0]  KP_RST    = 24'd53084;
    localparam logic [GAIN_W-1:0]  KI_RST    = 24'd26293;
    localparam logic [GAIN_W-1:0]  KD_RST    = 24'd32768;
    localparam logic [TRACK_W-1:0] TRACK_RST = 10'd207;
    localparam logic [SCALE_W-1:0] SCALE_RST = 16'd2961;

    typedef enum logic [2:0] {
        REG_LEFT_KP   = 3'd0,
        REG_LEFT_KI   = 3'd1,
        REG_LEFT_KD   = 3'd2,
        REG_RIGHT_KP  = 3'd3,
        REG_RIGHT_KI  = 3'd4,
        REG_RIGHT_KD  = 3'd5,
        REG_TRACK     = 3'd6,
        REG_SCALE     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  kp_l;
        logic [GAIN_W-1:0]  ki_l;
        logic [GAIN_W-1:0]  kd_l;
        logic [GAIN_W-1:0]  kp_r;
        logic [GAIN_W-1:0]  ki_r;
        logic [GAIN_W-1:0]  kd_r;
        logic [TRACK_W-1:0] track;
        logic [SCALE_W-1:0] scale;
    } cfg_t;

    typedef struct packed {
        logic               rev_r;
        logic               rev_l;
        logic [PWM_W-1:0]   pwm_r;
        logic [PWM_W-1:0]   pwm_l;
    } res_t;

    // multiply request: a is two's complement, b unsigned
    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

endpackage

`default_nettype wire

@@ rtl/dual_wheel_velocity_pid_unit.sv @@
// Each accepted request runs to its result in the output register before another is taken.
// Nine shift-add multiplies on one shared unit, each with start and done (speed
// split, then set-point, Kp, Ki and Kd per wheel), four steps per wheel and
// the output register load make up that run. A new request is accepted only in idle.
// Reset (rst_n, async low): gains and scales to defaults, PID sums, errors, drives to zero.
// Top level: APB register file, stream input and output register. Depends on dwvp_pkg, dwvp_core.
`default_nettype none

module dual_wheel_velocity_pid_unit import dwvp_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int TICK_BITS = 10
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // apb
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [APB_AW-1:0]    paddr,
    input  wire logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]         prdata,
    output logic                      pready,
    // input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [TICK_BITS-1:0] left_ticks, then right_ticks, linear_speed (13), turn_rate (16), zero pad
    input  wire logic [((2*TICK_BITS + LIN_W + TURN_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // output stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [7:0] left_pwm, [15:8] right_pwm, [16] left_reverse, [17] right_reverse, zero pad
    output logic [OUT_W-1:0]          m_axis_tdata
);

    localparam int RT_LO  = TICK_BITS;
    localparam int LIN_LO = 2 * TICK_BITS;
    localparam int TRN_LO = LIN_LO + LIN_W;

    cfg_t               cfg_reg;
    logic               m_tvalid_reg;
    logic [OUT_W-1:0]   m_tdata_reg;

    logic               item_start;
    logic               core_ready;
    logic               res_valid;
    logic               res_take;
    res_t               res;
    logic               wr_en;
    reg_idx_t           reg_idx;

    assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_l  <= KP_RST;
            cfg_reg.ki_l  <= KI_RST;
            cfg_reg.kd_l  <= KD_RST;
            cfg_reg.kp_r  <= KP_RST;
            cfg_reg.ki_r  <= KI_RST;
            cfg_reg.kd_r  <= KD_RST;
            cfg_reg.track <= TRACK_RST;
            cfg_reg.scale <= SCALE_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_LEFT_KP:  cfg_reg.kp_l  <= pwdata[GAIN_W-1:0];
                REG_LEFT_KI:  cfg_reg.ki_l  <= pwdata[GAIN_W-1:0];
                REG_LEFT_KD:  cfg_reg.kd_l  <= pwdata[GAIN_W-1:0];
                REG_RIGHT_KP: cfg_reg.kp_r  <= pwdata[GAIN_W-1:0];
                REG_RIGHT_KI: cfg_reg.ki_r  <= pwdata[GAIN_W-1:0];
                REG_RIGHT_KD: cfg_reg.kd_r  <= pwdata[GAIN_W-1:0];
                REG_TRACK:    cfg_reg.track <= pwdata[TRACK_W-1:0];
                REG_SCALE:    cfg_reg.scale <= pwdata[SCALE_W-1:0];
                default:      cfg_reg       <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_LEFT_KP:  prdata = APB_DW'(cfg_reg.kp_l);
            REG_LEFT_KI:  prdata = APB_DW'(cfg_reg.ki_l);
            REG_LEFT_KD:  prdata = APB_DW'(cfg_reg.kd_l);
            REG_RIGHT_KP: prdata = APB_DW'(cfg_reg.kp_r);
            REG_RIGHT_KI: prdata = APB_DW'(cfg_reg.ki_r);
            REG_RIGHT_KD: prdata = APB_DW'(cfg_reg.kd_r);
            REG_TRACK:    prdata = APB_DW'(cfg_reg.track);
            REG_SCALE:    prdata = APB_DW'(cfg_reg.scale);
            default:      prdata = '0;
        endcase
    end

    assign s_axis_tready = core_ready;
    assign item_start    = s_axis_tvalid & core_ready;

    dwvp_core #(
        .FRAC_BITS (FRAC_BITS),
        .TICK_BITS (TICK_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .item_start   (item_start),
        .left_ticks   ($signed(s_axis_tdata[TICK_BITS-1:0])),
        .right_ticks  ($signed(s_axis_tdata[RT_LO +: TICK_BITS])),
        .linear_speed ($signed(s_axis_tdata[LIN_LO +: LIN_W])),
        .turn_rate    ($signed(s_axis_tdata[TRN_LO +: TURN_W])),
        .ready        (core_ready),
        .res_valid    (res_valid),
        .res          (res),
        .res_take     (res_take)
    );

    // output register frees the core while the result waits downstream
    assign res_take = res_valid & (~m_tvalid_reg | m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (res_take)
            m_tvalid_reg <= 1'b1;
        else if (m_axis_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
            m_tdata_reg <= OUT_W'({res.rev_r, res.rev_l, res.pwm_r, res.pwm_l});
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

@@ rtl/dwvp_mul.sv @@
// Serial-parallel shift-add multiplier, one multiplier bit per cycle.
// Depends on dwvp_pkg (mul_req_t and operand widths).
`default_nettype none

module dwvp_mul import dwvp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mul_req_t          req,
    output logic                   done,
    output logic [PROD_W-1:0]      prod
);

    localparam int CNT_W = $clog2(MUL_B_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [MUL_A_W-1:0]   a_reg;
    logic [MUL_A_W:0]     h_reg;
    logic [MUL_B_W-1:0]   l_reg;
    logic [MUL_A_W:0]     h_sum;

    always_comb
    begin
        if (l_reg[0])
            h_sum = h_reg + {a_reg[MUL_A_W-1], a_reg};
        else
            h_sum = h_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MUL_B_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // partial product shifts right into l_reg as multiplier bits retire
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= req.a;
            h_reg <= '0;
            l_reg <= req.b;
        end
        else if (busy_reg)
        begin
            h_reg <= {h_sum[MUL_A_W], h_sum[MUL_A_W:1]};
            l_reg <= {h_sum[0], l_reg[MUL_B_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = {h_reg[MUL_A_W-1:0], l_reg};

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("multiply request while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("multiply done without a finished run");

endmodule

`default_nettype wire

@@ rtl/dwvp_core.sv @@
// Sequencer and datapath for both wheels: speed split, set-point, PID, drive.
// Depends on dwvp_pkg and dwvp_mul (shared serial multiplier).
`default_nettype none

module dwvp_core import dwvp_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int TICK_BITS = 10
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cfg_t                        cfg,
    input  wire logic                        item_start,
    input  wire logic signed [TICK_BITS-1:0] left_ticks,
    input  wire logic signed [TICK_BITS-1:0] right_ticks,
    input  wire logic signed [LIN_W-1:0]     linear_speed,
    input  wire logic signed [TURN_W-1:0]    turn_rate,
    output logic                             ready,
    output logic                             res_valid,
    output res_t                             res,
    input  wire logic                        res_take
);

    localparam int DRV_W  = FRAC_BITS + 10;
    localparam int SET_SH = SET_SH_BASE - FRAC_BITS;
    localparam int SET_W  = SETP_W - SET_SH;
    localparam int ATS_W  = TICK_BITS + FRAC_BITS;
    localparam int EW     = ((SET_W > ATS_W) ? SET_W : ATS_W) + 1;
    localparam int XW     = (EW > ERR_W + 1) ? EW : ERR_W + 1;
    localparam int SUM_W  = ACC_W + 1;

    localparam logic signed [XW-1:0]    E_HI = XW'(ERR_MAX);
    localparam logic signed [XW-1:0]    E_LO = ~E_HI;
    localparam logic signed [SUM_W-1:0] D_HI = SUM_W'(DRV_MAX_INT) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] D_LO = -D_HI;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPIN,
        ST_SET,
        ST_ERR,
        ST_UPD,
        ST_KP,
        ST_KI,
        ST_KD,
        ST_DRV,
        ST_CLMP,
        ST_DONE
    } state_t;

    state_t                      state_reg;
    logic                        wheel_reg;
    logic                        mstart_reg;
    logic signed [ERR_W-1:0]     sum_reg   [2];
    logic signed [ERR_W-1:0]     last_reg  [2];
    logic signed [DRV_W-1:0]     drive_reg [2];
    res_t                        res_reg;

    logic signed [TICK_BITS-1:0] lt_reg, rt_reg;
    logic signed [LIN_W-1:0]     lin_reg;
    logic signed [TURN_W-1:0]    turn_reg;
    logic signed [VEL_W-1:0]     tv_reg [2];
    logic [SET_W-1:0]            set_reg;
    logic signed [ERR_W-1:0]     e_reg;
    logic signed [ERR_W:0]       de_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [SUM_W-1:0]     dsum_reg;

    mul_req_t                    mreq;
    logic                        mul_done;
    logic [PROD_W-1:0]           mul_prod;
    logic signed [PROD_W-1:0]    prod_s;

    logic signed [VEL_W-1:0]     tv_cur, base, spin;
    logic [VEL_W-1:0]            mag;
    logic signed [TICK_BITS-1:0] ticks_cur;
    logic [TICK_BITS-1:0]        at_mag;
    logic [ATS_W-1:0]            at_sh;
    logic signed [XW-1:0]        diff;
    logic signed [ERR_W-1:0]     e_sat;
    logic signed [ERR_W:0]       sum_add;
    logic signed [ERR_W-1:0]     sum_sat;
    logic signed [ERR_W:0]       de_new;
    logic signed [ACC_W-1:0]     out_sh;
    logic signed [SUM_W-1:0]     dsum_new;
    logic signed [DRV_W-1:0]     drive_new;
    logic                        set_zero;
    logic [PWM_W-1:0]            pwm_new;
    logic                        rev_new;
    logic [GAIN_W-1:0]           kp_cur, ki_cur, kd_cur;

    dwvp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    assign prod_s = $signed(mul_prod);

    always_comb
    begin
        kp_cur = wheel_reg ? cfg.kp_r : cfg.kp_l;
        ki_cur = wheel_reg ? cfg.ki_r : cfg.ki_l;
        kd_cur = wheel_reg ? cfg.kd_r : cfg.kd_l;

        base = {{(VEL_W - LIN_W - BASE_SH){lin_reg[LIN_W-1]}}, lin_reg, {BASE_SH{1'b0}}};
        spin = prod_s[VEL_W-1:0];

        tv_cur = tv_reg[wheel_reg];
        mag    = tv_cur[VEL_W-1] ? VEL_W'(-tv_cur) : VEL_W'(tv_cur);

        // magnitude of the most negative count wraps to the right unsigned value
        ticks_cur = wheel_reg ? rt_reg : lt_reg;
        at_mag    = ticks_cur[TICK_BITS-1] ? TICK_BITS'(-ticks_cur) : TICK_BITS'(ticks_cur);
        at_sh     = {at_mag, {FRAC_BITS{1'b0}}};

        diff = $signed(XW'(set_reg)) - $signed(XW'(at_sh));
        if (diff > E_HI)
            e_sat = ERR_MAX;
        else if (diff < E_LO)
            e_sat = ERR_MIN;
        else
            e_sat = diff[ERR_W-1:0];

        sum_add = {sum_reg[wheel_reg][ERR_W-1], sum_reg[wheel_reg]} + {e_reg[ERR_W-1], e_reg};
        if (sum_add[ERR_W] != sum_add[ERR_W-1])
            sum_sat = sum_add[ERR_W] ? ERR_MIN : ERR_MAX;
        else
            sum_sat = sum_add[ERR_W-1:0];

        de_new = {e_reg[ERR_W-1], e_reg} - {last_reg[wheel_reg][ERR_W-1], last_reg[wheel_reg]};

        out_sh   = acc_reg >>> FRAC_BITS;
        dsum_new = SUM_W'(drive_reg[wheel_reg]) + SUM_W'(out_sh);

        set_zero = (set_reg == '0);
        if (set_zero)
            drive_new = '0;
        else if (dsum_reg > D_HI)
            drive_new = D_HI[DRV_W-1:0];
        else if (dsum_reg < D_LO)
            drive_new = D_LO[DRV_W-1:0];
        else
            drive_new = dsum_reg[DRV_W-1:0];

        pwm_new = drive_new[DRV_W-1] ? '0 : drive_new[FRAC_BITS +: PWM_W];
        rev_new = tv_cur[VEL_W-1] | set_zero;
    end

    // operands follow the state; the unit latches them on the start pulse
    always_comb
    begin
        mreq.start = mstart_reg;
        case (state_reg)
            ST_SPIN:
            begin
                mreq.a = MUL_A_W'(turn_reg);
                mreq.b = MUL_B_W'(cfg.track);
            end
            ST_SET:
            begin
                mreq.a = MUL_A_W'(mag);
                mreq.b = MUL_B_W'(cfg.scale);
            end
            ST_KP:
            begin
                mreq.a = MUL_A_W'(e_reg);
                mreq.b = kp_cur;
            end
            ST_KI:
            begin
                mreq.a = MUL_A_W'(sum_reg[wheel_reg]);
                mreq.b = ki_cur;
            end
            ST_KD:
            begin
                mreq.a = MUL_A_W'(de_reg);
                mreq.b = kd_cur;
            end
            default:
            begin
                mreq.a = '0;
                mreq.b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            wheel_reg    <= 1'b0;
            mstart_reg   <= 1'b0;
            sum_reg[0]   <= '0;
            sum_reg[1]   <= '0;
            last_reg[0]  <= '0;
            last_reg[1]  <= '0;
            drive_reg[0] <= '0;
            drive_reg[1] <= '0;
            res_reg      <= '0;
        end
        else
        begin
            mstart_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    wheel_reg <= 1'b0;
                    if (item_start)
                    begin
                        state_reg  <= ST_SPIN;
                        mstart_reg <= 1'b1;
                    end
                end
                ST_SPIN:
                begin
                    if (mul_done)
                    begin
                        state_reg  <= ST_SET;
                        mstart_reg <= 1'b1;
                    end
                end
                ST_SET:
                begin
                    if (mul_done)
                        state_reg <= ST_ERR;
                end
                ST_ERR:
                begin
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    sum_reg[wheel_reg]  <= sum_sat;
                    last_reg[wheel_reg] <= e_reg;
                    state_reg           <= ST_KP;
                    mstart_reg          <= 1'b1;
                end
                ST_KP:
                begin
                    if (mul_done)
                    begin
                        state_reg  <= ST_KI;
                        mstart_reg <= 1'b1;
                    end
                end
                ST_KI:
                begin
                    if (mul_done)
                    begin
                        state_reg  <= ST_KD;
                        mstart_reg <= 1'b1;
                    end
                end
                ST_KD:
                begin
                    if (mul_done)
                        state_reg <= ST_DRV;
                end
                ST_DRV:
                begin
                    state_reg <= ST_CLMP;
                end
                ST_CLMP:
                begin
                    drive_reg[wheel_reg] <= drive_new;
                    if (wheel_reg)
                    begin
                        res_reg.pwm_r <= pwm_new;
                        res_reg.rev_r <= rev_new;
                        state_reg     <= ST_DONE;
                    end
                    else
                    begin
                        res_reg.pwm_l <= pwm_new;
                        res_reg.rev_l <= rev_new;
                        wheel_reg     <= 1'b1;
                        state_reg     <= ST_SET;
                        mstart_reg    <= 1'b1;
                    end
                end
                ST_DONE:
                begin
                    if (res_take)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && item_start)
        begin
            lt_reg   <= left_ticks;
            rt_reg   <= right_ticks;
            lin_reg  <= linear_speed;
            turn_reg <= turn_rate;
        end
        if (state_reg == ST_SPIN && mul_done)
        begin
            tv_reg[0] <= base + spin;
            tv_reg[1] <= base - spin;
        end
        if (state_reg == ST_SET && mul_done)
            set_reg <= mul_prod[SET_SH +: SET_W];
        if (state_reg == ST_ERR)
            e_reg <= e_sat;
        if (state_reg == ST_UPD)
            de_reg <= de_new;
        if (state_reg == ST_KP && mul_done)
            acc_reg <= ACC_W'(prod_s);
        if ((state_reg == ST_KI || state_reg == ST_KD) && mul_done)
            acc_reg <= acc_reg + ACC_W'(prod_s);
        if (state_reg == ST_DRV)
            dsum_reg <= dsum_new;
    end

    assign ready     = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        SUM_W'(drive_reg[0]) <= D_HI && SUM_W'(drive_reg[0]) >= D_LO &&
        SUM_W'(drive_reg[1]) <= D_HI && SUM_W'(drive_reg[1]) >= D_LO)
        else $error("drive outside saturation range");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_start |-> state_reg == ST_IDLE)
        else $error("item request taken while busy");

    a_done_both: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE |-> wheel_reg)
        else $error("result ready before right wheel finished");

    a_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_SPIN || state_reg == ST_SET ||
                      state_reg == ST_KP || state_reg == ST_KI || state_reg == ST_KD))
        else $error("multiply finished outside a multiply step");

endmodule

`default_nettype wire

@@ bench/dual_wheel_velocity_pid_unit_tb.sv @@
// Self-checking bench for dual_wheel_velocity_pid_unit: stream requests in, PWM/direction out.
// Carries its own bit-accurate PID predictor and APB register shadow.
// Depends on rtl/dwvp_pkg.sv and the unit's RTL.
`timescale 1ns / 1ps

module dual_wheel_velocity_pid_unit_tb;
    import dwvp_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int TICK_BITS = 10;
    localparam int FIELD_W = 2 * TICK_BITS + LIN_W + TURN_W;
    localparam int IN_W = ((FIELD_W + 7) / 8) * 8;
    localparam int PAD_W = IN_W - FIELD_W;
    localparam int SET_SHIFT = SET_SH_BASE - FRAC_BITS;
    localparam longint ERR_HI = 64'sd2147483647;
    localparam longint ERR_LO = -64'sd2147483648;
    localparam longint DRIVE_LIM = longint'(DRV_MAX_INT) << FRAC_BITS;
    localparam longint TICK_MAX = (longint'(1) << (TICK_BITS - 1)) - 1;
    localparam int DIR_N = 18;
    localparam int NUM_PHASES = 12;
    localparam int ITEMS_PER_PHASE = 49;
    localparam int PRESSURE_PHASE = 5;
    localparam int HOLD_CYCLES = 3000;
    localparam int QUIET_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 300;

    typedef struct packed {
        logic signed [TICK_BITS-1:0] left_ticks;
        logic signed [TICK_BITS-1:0] right_ticks;
        logic signed [LIN_W-1:0]     linear_speed;
        logic signed [TURN_W-1:0]    turn_rate;
    } pid_cmd_t;

    typedef struct packed {
        pid_cmd_t cmd;
        logic     typed;
        res_t     want;
    } stim_row_t;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // left_ticks, right_ticks, linear_speed, turn_rate, zero pad (lowest bit first)
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // left_pwm, right_pwm, left_reverse, right_reverse, zero pad (lowest bit first)
    logic [OUT_W-1:0]  m_axis_tdata;

    // register shadow, index 0 = left wheel, 1 = right wheel
    logic [GAIN_W-1:0]  kp_g [2] = '{KP_RST, KP_RST};
    logic [GAIN_W-1:0]  ki_g [2] = '{KI_RST, KI_RST};
    logic [GAIN_W-1:0]  kd_g [2] = '{KD_RST, KD_RST};
    logic [TRACK_W-1:0] track_g = TRACK_RST;
    logic [SCALE_W-1:0] scale_g = SCALE_RST;

    // PID state per wheel
    longint err_sum [2] = '{0, 0};
    longint last_err [2] = '{0, 0};
    longint drive [2] = '{0, 0};

    res_t wheel_out_q [$];
    int   mismatch_cnt = 0;
    int   quiet_cycles = 0;
    int   tx_idle_pct = 0;
    int   rx_stall_pct = 0;
    int   hold_ask = 0;
    int   hold_seen = 0;

    // zero-command rows, saturating rows, small-value rows and the truncated-to-zero set-point rows
    stim_row_t dir_rows [DIR_N] = '{
        '{'{10'sd0, 10'sd0, 13'sd0, 16'sd0}, 1'b1, '{1'b1, 1'b1, 8'd0, 8'd0}},
        '{'{10'sd0, 10'sd0, 13'sd4095, 16'sd0}, 1'b1, '{1'b0, 1'b0, 8'd255, 8'd255}},
        '{'{10'sd0, 10'sd0, -13'sd4096, 16'sd0}, 1'b1, '{1'b1, 1'b1, 8'd255, 8'd255}},
        '{'{-10'sd512, 10'sd511, 13'sd0, 16'sd0}, 1'b1, '{1'b1, 1'b1, 8'd0, 8'd0}},
        '{'{10'sd511, -10'sd512, 13'sd4095, 16'sd0}, 1'b0, '0},
        '{'{10'sd0, 10'sd0, 13'sd0, 16'sd32767}, 1'b0, '0},
        '{'{10'sd0, 10'sd0, 13'sd0, -16'sd32768}, 1'b0, '0},
        '{'{-10'sd512, -10'sd512, 13'sd4095, 16'sd32767}, 1'b0, '0},
        '{'{10'sd511, 10'sd511, -13'sd4096, -16'sd32768}, 1'b0, '0},
        '{'{10'sd4, 10'sd5, 13'sd100, 16'sd0}, 1'b0, '0},
        '{'{10'sd5, 10'sd4, 13'sd100, 16'sd0}, 1'b0, '0},
        '{'{10'sd4, 10'sd4, 13'sd100, 16'sd0}, 1'b0, '0},
        '{'{10'sd5, 10'sd5, 13'sd100, 16'sd0}, 1'b0, '0},
        '{'{10'sd1, -10'sd1, 13'sd0, 16'sd1}, 1'b0, '0},
        '{'{10'sd0, 10'sd0, 13'sd1, 16'sd0}, 1'b0, '0},
        '{'{10'sd3, -10'sd3, -13'sd1, 16'sd40}, 1'b0, '0},
        // twice the left wheel speed is +1 in Q.12: set-point truncates to zero
        '{'{10'sd0, 10'sd0, -13'sd40, 16'sd1583}, 1'b0, '0},
        // same for the right wheel
        '{'{-10'sd1, 10'sd1, -13'sd40, -16'sd1583}, 1'b0, '0}
    };

    dual_wheel_velocity_pid_unit #(
        .FRAC_BITS (FRAC_BITS),
        .TICK_BITS (TICK_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    // one wheel: PID on set magnitude minus |ticks|, drive accumulates the output
    function automatic void step_wheel(input int w, input longint twice_v, input longint ticks,
                                       output logic [PWM_W-1:0] pwm, output logic rev);
        longint mag, setp, e, acc, duty;
        mag = twice_v < 0 ? -twice_v : twice_v;
        setp = (mag * longint'(scale_g)) >>> SET_SHIFT;
        e = clip(setp - ((ticks < 0 ? -ticks : ticks) << FRAC_BITS), ERR_LO, ERR_HI);
        rev = twice_v < 0;
        err_sum[w] = clip(err_sum[w] + e, ERR_LO, ERR_HI);
        acc = longint'(kp_g[w]) * e + longint'(ki_g[w]) * err_sum[w]
            + longint'(kd_g[w]) * (e - last_err[w]);
        last_err[w] = e;
        drive[w] = clip(drive[w] + (acc >>> FRAC_BITS), -DRIVE_LIM, DRIVE_LIM);
        if (setp == 0)
        begin
            drive[w] = 0;
            rev = 1'b1;
        end
        duty = clip(drive[w] >>> FRAC_BITS, 0, 255);
        pwm = duty[PWM_W-1:0];
    endfunction

    function automatic res_t predict_wheels(input pid_cmd_t c);
        res_t r;
        longint base, spin;
        base = longint'(c.linear_speed) * 8192;
        spin = longint'(c.turn_rate) * longint'(track_g);
        step_wheel(0, base + spin, longint'(c.left_ticks), r.pwm_l, r.rev_l);
        step_wheel(1, base - spin, longint'(c.right_ticks), r.pwm_r, r.rev_r);
        return r;
    endfunction

    // encoder count near the set-point, so the loop settles at partial duty
    function automatic logic signed [TICK_BITS-1:0] near_ticks(input longint twice_v);
        longint est;
        est = ((twice_v < 0 ? -twice_v : twice_v) * longint'(scale_g))
            >>> (SET_SHIFT + FRAC_BITS);
        est = clip(est + longint'($urandom_range(16)) - 8, 0, TICK_MAX);
        if ($urandom_range(3) == 0)
            est = -est;
        return TICK_BITS'(est);
    endfunction

    task automatic send_cmd(input pid_cmd_t c, input logic typed, input res_t want);
        res_t calc;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{PAD_W{1'b0}}, c.turn_rate, c.linear_speed, c.right_ticks,
                         c.left_ticks};
        do @(posedge clk); while (!s_axis_tready);
        calc = predict_wheels(c);
        wheel_out_q.push_back(typed ? want : calc);
    endtask

    // write, then read back; upper bits beyond the register width are junk
    task automatic cfg_write(input reg_idx_t r, input logic [31:0] v);
        int w;
        logic [31:0] kept, rd;
        case (r)
            REG_TRACK: w = TRACK_W;
            REG_SCALE: w = SCALE_W;
            default:   w = GAIN_W;
        endcase
        kept = v & ((32'd1 << w) - 32'd1);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= kept | ($urandom_range(1) != 0 ? ($urandom() << w) : 32'd0);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (r)
            REG_LEFT_KP:  kp_g[0] = kept[GAIN_W-1:0];
            REG_LEFT_KI:  ki_g[0] = kept[GAIN_W-1:0];
            REG_LEFT_KD:  kd_g[0] = kept[GAIN_W-1:0];
            REG_RIGHT_KP: kp_g[1] = kept[GAIN_W-1:0];
            REG_RIGHT_KI: ki_g[1] = kept[GAIN_W-1:0];
            REG_RIGHT_KD: kd_g[1] = kept[GAIN_W-1:0];
            REG_TRACK:    track_g = kept[TRACK_W-1:0];
            REG_SCALE:    scale_g = kept[SCALE_W-1:0];
            default:      ;
        endcase
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd !== kept)
        begin
            $error("%s readback: expected %h, actual %h", r.name(), kept, rd);
            mismatch_cnt++;
        end
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (wheel_out_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int ph, n, r, kind, lin, turn;
        longint twice_l, twice_r;
        pid_cmd_t c;
        logic [31:0] cfg_val [8];
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < DIR_N; n++)
            send_cmd(dir_rows[n].cmd, dir_rows[n].typed, dir_rows[n].want);
        s_axis_tvalid <= 1'b0;

        lin = 0;
        turn = 0;
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drained();
            repeat (2) @(posedge clk);
            case (ph)
                0:
                begin
                    for (r = 0; r < 6; r++)
                        cfg_val[r] = 32'h00FF_FFFF;
                    cfg_val[REG_TRACK] = 32'd1023;
                    cfg_val[REG_SCALE] = 32'h0000_FFFF;
                end
                1:
                begin
                    for (r = 0; r < 6; r++)
                        cfg_val[r] = 32'd0;
                    cfg_val[REG_TRACK] = 32'd1;
                    cfg_val[REG_SCALE] = 32'd1;
                end
                2:
                begin
                    for (r = 0; r < 6; r++)
                        cfg_val[r] = $urandom_range(131072);
                    cfg_val[REG_TRACK] = 32'd1;
                    cfg_val[REG_SCALE] = 32'd0;
                end
                default:
                begin
                    for (r = 0; r < 6; r++)
                        cfg_val[r] = $urandom_range(3) == 0 ? $urandom_range(24'hFF_FFFF)
                                                            : $urandom_range(131072);
                    cfg_val[REG_TRACK] = $urandom_range(1, 1023);
                    cfg_val[REG_SCALE] = $urandom_range(3) == 0 ? $urandom_range(65535)
                                                                : $urandom_range(1000, 6000);
                end
            endcase
            for (r = 0; r < 8; r++)
                cfg_write(reg_idx_t'(r), cfg_val[r]);

            case (ph % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 49; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 49; end
                default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
            endcase
            if (ph == PRESSURE_PHASE)
                hold_ask <= hold_ask + 1;

            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                kind = $urandom_range(99);
                if (kind < 20)
                begin
                    c.left_ticks = TICK_BITS'($urandom());
                    c.right_ticks = TICK_BITS'($urandom());
                    c.linear_speed = LIN_W'($urandom());
                    c.turn_rate = TURN_W'($urandom());
                end
                else
                begin
                    // hold the command over several ticks so the loop can settle
                    if (n == 0 || $urandom_range(3) == 0)
                    begin
                        if ($urandom_range(7) == 0)
                        begin
                            lin = 0;
                            turn = int'($urandom_range(6)) - 3;
                        end
                        else
                        begin
                            lin = int'($urandom_range(1200)) - 600;
                            turn = int'($urandom_range(8000)) - 4000;
                        end
                    end
                    twice_l = longint'(lin) * 8192 + longint'(turn) * longint'(track_g);
                    twice_r = longint'(lin) * 8192 - longint'(turn) * longint'(track_g);
                    c.linear_speed = LIN_W'(lin);
                    c.turn_rate = TURN_W'(turn);
                    c.left_ticks = near_ticks(twice_l);
                    c.right_ticks = near_ticks(twice_r);
                end
                send_cmd(c, 1'b0, '0);
            end
            s_axis_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("dual_wheel_velocity_pid_unit_tb passed");
        else
            $display("dual_wheel_velocity_pid_unit_tb failed");
        $finish;
    end

    // result side: random stalls, plus one long hold-off to back up the input
    initial
    begin : result_sink
        forever
        begin
            @(posedge clk);
            if (hold_ask != hold_seen)
            begin
                hold_seen = hold_ask;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= ($urandom_range(99) < rx_stall_pct) ? 1'b0 : 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        res_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
            if (wheel_out_q.size() == 0)
            begin
                $error("result with no request pending: %h", m_axis_tdata);
                mismatch_cnt++;
            end
            else
            begin
                want = wheel_out_q.pop_front();
                if (got.pwm_l !== want.pwm_l)
                begin
                    $error("left_pwm: expected %0d, actual %0d", want.pwm_l, got.pwm_l);
                    mismatch_cnt++;
                end
                if (got.pwm_r !== want.pwm_r)
                begin
                    $error("right_pwm: expected %0d, actual %0d", want.pwm_r, got.pwm_r);
                    mismatch_cnt++;
                end
                if (got.rev_l !== want.rev_l)
                begin
                    $error("left_reverse: expected %0b, actual %0b", want.rev_l, got.rev_l);
                    mismatch_cnt++;
                end
                if (got.rev_r !== want.rev_r)
                begin
                    $error("right_reverse: expected %0b, actual %0b", want.rev_r, got.rev_r);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("dual_wheel_velocity_pid_unit_tb failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
